/* sv/vln_pkg.sv */
// Shared types and constants for the vector length normalizer.
// Used by every module of the block; depends on nothing.
package vln_pkg;

  localparam int EL_W       = 16;   // element width, signed Q4.12
  localparam int SUM_W      = 36;   // sum-of-squares width, Q12.24
  localparam int ROOT_W     = SUM_W / 2;
  localparam int SQRT_STEPS = SUM_W / 2;
  localparam int SQRT_TOP   = SUM_W - 2;
  localparam int NUM_W      = 2 * EL_W;
  localparam int QBITS      = EL_W - 1;  // quotient bits below the saturation point
  localparam int STEP_W     = 5;
  localparam int CFG_W      = 32;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ACC,
    ST_SQRT,
    ST_READ,
    ST_MUL,
    ST_DINIT,
    ST_DIV,
    ST_EMIT
  } state_t;

  typedef enum logic [2:0] {
    U_HOLD,
    U_SQRT_INIT,
    U_SQRT_STEP,
    U_DIV_INIT,
    U_DIV_STEP
  } unit_op_t;

  typedef struct packed {
    unit_op_t op;
  } unit_ctrl_t;

  typedef struct packed {
    logic [ROOT_W-1:0] root;
    logic [QBITS-1:0]  quot;
    logic              ovf;
  } unit_stat_t;

endpackage

/* sv/vector_length_normalize_core.sv */
// Vector length normalizer. Loading takes one element per cycle (busy low).
// After the last element the sum is closed and the root found; then each element
// is read, multiplied and, when scaled, divided (15-step division in the shared
// compare-subtract unit), then emitted; each result shows in the cycle after its
// emit step. Results cannot be stalled. Reset clears the control state and config
// registers; the datapath registers and the element memory are not cleared.
module vector_length_normalize_core #(
  parameter int MAX_ELEMENTS = 32
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  output logic                      busy,
  input  logic signed [15:0]        element,
  input  logic                      last,
  output logic                      strobe,
  output logic signed [15:0]        scaled,
  output logic                      final_res,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [2:0]                paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready
);

  localparam int CNT_W = $clog2(MAX_ELEMENTS + 1);
  localparam int IDX_W = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
  localparam int SW    = vln_pkg::SUM_W;
  localparam int EW    = vln_pkg::EL_W;

  vln_pkg::state_t     state, state_next;
  vln_pkg::unit_ctrl_t uctrl;
  vln_pkg::unit_stat_t ustat;

  logic [15:0]                 target_length;
  logic [31:0]                 min_energy;
  logic [CNT_W-1:0]            fill_count;
  logic [IDX_W-1:0]            idx;
  logic [vln_pkg::STEP_W-1:0]  step;
  logic [SW-1:0]               square_sum, sum_next;
  logic [SW:0]                 sum_wide;
  logic [2*EW-1:0]             prod;
  logic                        pend;
  logic [EW-1:0]               in_mag, rd_mag;
  logic [EW-1:0]               rd_data;
  logic [vln_pkg::NUM_W-1:0]   num;
  logic                        neg;
  logic                        accept;
  logic                        room;
  logic                        pass;
  logic                        at_end;
  logic [EW-1:0]               q_mag;
  logic [EW-1:0]               result;

  vln_regs u_regs (
    .clk           (clk),
    .rst           (rst),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .target_length (target_length),
    .min_energy    (min_energy)
  );

  assign busy   = (state != vln_pkg::ST_IDLE);
  assign accept = start & ~busy;
  assign room   = fill_count < CNT_W'(MAX_ELEMENTS);

  vln_store #(
    .DEPTH (MAX_ELEMENTS),
    .AW    (IDX_W)
  ) u_store (
    .clk     (clk),
    .wr_en   (accept & room),
    .wr_addr (fill_count[IDX_W-1:0]),
    .wr_data (element),
    .rd_en   (state == vln_pkg::ST_READ),
    .rd_addr (idx),
    .rd_data (rd_data)
  );

  vln_unit u_unit (
    .clk    (clk),
    .ctrl   (uctrl),
    .sum_in (sum_next),
    .num_in (num),
    .stat   (ustat)
  );

  assign in_mag = element[EW-1] ? (~element + 1'b1) : element;
  assign rd_mag = rd_data[EW-1] ? (~rd_data + 1'b1) : rd_data;

  // Squares are registered and added in the following cycle, saturating at the top.
  always_comb begin
    sum_wide = {1'b0, square_sum} + {{(SW + 1 - 2 * EW){1'b0}}, prod};
    if (!pend) begin
      sum_next = square_sum;
    end else if (sum_wide[SW]) begin
      sum_next = '1;
    end else begin
      sum_next = sum_wide[SW-1:0];
    end
  end

  assign pass   = (square_sum < SW'(min_energy)) || (ustat.root == '0);
  assign at_end = (CNT_W'(idx) + CNT_W'(1)) == fill_count;
  assign q_mag  = {1'b0, ustat.quot};

  always_comb begin
    if (pass) begin
      result = rd_data;
    end else if (ustat.ovf) begin
      result = neg ? 16'h8000 : 16'h7FFF;
    end else begin
      result = neg ? (~q_mag + 1'b1) : q_mag;
    end
  end

  always_comb begin
    state_next = state;
    uctrl.op   = vln_pkg::U_HOLD;
    unique case (state)
      vln_pkg::ST_IDLE: begin
        if (accept && last) begin
          state_next = vln_pkg::ST_ACC;
        end
      end
      vln_pkg::ST_ACC: begin
        uctrl.op   = vln_pkg::U_SQRT_INIT;
        state_next = vln_pkg::ST_SQRT;
      end
      vln_pkg::ST_SQRT: begin
        uctrl.op = vln_pkg::U_SQRT_STEP;
        if (step == vln_pkg::STEP_W'(vln_pkg::SQRT_STEPS - 1)) begin
          state_next = vln_pkg::ST_READ;
        end
      end
      vln_pkg::ST_READ: begin
        state_next = vln_pkg::ST_MUL;
      end
      vln_pkg::ST_MUL: begin
        state_next = pass ? vln_pkg::ST_EMIT : vln_pkg::ST_DINIT;
      end
      vln_pkg::ST_DINIT: begin
        uctrl.op   = vln_pkg::U_DIV_INIT;
        state_next = vln_pkg::ST_DIV;
      end
      vln_pkg::ST_DIV: begin
        uctrl.op = vln_pkg::U_DIV_STEP;
        if (step == vln_pkg::STEP_W'(vln_pkg::QBITS - 1)) begin
          state_next = vln_pkg::ST_EMIT;
        end
      end
      vln_pkg::ST_EMIT: begin
        state_next = at_end ? vln_pkg::ST_IDLE : vln_pkg::ST_READ;
      end
      default: begin
        state_next = vln_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= vln_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill_count <= '0;
      square_sum <= '0;
      pend       <= 1'b0;
      idx        <= '0;
      step       <= '0;
      strobe     <= 1'b0;
      final_res  <= 1'b0;
    end else begin
      pend       <= accept & room;
      strobe     <= (state == vln_pkg::ST_EMIT);
      if (state == vln_pkg::ST_EMIT && at_end) begin
        square_sum <= '0;
      end else begin
        square_sum <= sum_next;
      end
      if (accept && room) begin
        fill_count <= fill_count + 1'b1;
      end
      if (state == vln_pkg::ST_SQRT || state == vln_pkg::ST_DIV) begin
        step <= step + 1'b1;
      end else begin
        step <= '0;
      end
      if (state == vln_pkg::ST_ACC) begin
        idx <= '0;
      end
      if (state == vln_pkg::ST_EMIT) begin
        final_res <= at_end;
        idx       <= idx + 1'b1;
        if (at_end) begin
          fill_count <= '0;
        end
      end
    end
  end

  // Datapath registers without reset.
  always_ff @(posedge clk) begin
    if (accept && room) begin
      prod <= in_mag * in_mag;
    end
    if (state == vln_pkg::ST_MUL) begin
      num <= rd_mag * target_length;
      neg <= rd_data[EW-1];
    end
    if (state == vln_pkg::ST_EMIT) begin
      scaled <= result;
    end
  end

endmodule

/* sv/vln_regs.sv */
// Configuration registers behind a simple APB-style port.
// Depends on vln_pkg.
module vln_regs (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [2:0]                paddr,
  input  logic [vln_pkg::CFG_W-1:0] pwdata,
  output logic [vln_pkg::CFG_W-1:0] prdata,
  output logic                      pready,
  output logic [15:0]               target_length,
  output logic [31:0]               min_energy
);

  logic wr;

  assign wr     = psel & penable & pwrite;
  assign pready = 1'b1;
  assign prdata = paddr[2] ? min_energy : {16'b0, target_length};

  always_ff @(posedge clk) begin
    if (rst) begin
      target_length <= 16'd4096;
      min_energy    <= 32'd1;
    end else if (wr) begin
      if (paddr[2]) begin
        min_energy <= pwdata;
      end else begin
        target_length <= pwdata[15:0];
      end
    end
  end

endmodule

/* sv/vln_store.sv */
// Element memory: one write port, one registered read port.
// Depends on vln_pkg for the element width.
module vln_store #(
  parameter int DEPTH = 32,
  parameter int AW    = 5
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [AW-1:0]            wr_addr,
  input  logic [vln_pkg::EL_W-1:0] wr_data,
  input  logic                     rd_en,
  input  logic [AW-1:0]            rd_addr,
  output logic [vln_pkg::EL_W-1:0] rd_data
);

  logic [vln_pkg::EL_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* sv/vln_unit.sv */
// Shared compare-subtract unit that runs the bitwise square root and the
// restoring division one step per cycle. Depends on vln_pkg.
module vln_unit (
  input  logic                       clk,
  input  vln_pkg::unit_ctrl_t        ctrl,
  input  logic [vln_pkg::SUM_W-1:0]  sum_in,
  input  logic [vln_pkg::NUM_W-1:0]  num_in,
  output vln_pkg::unit_stat_t        stat
);

  localparam int SW = vln_pkg::SUM_W;
  localparam int QB = vln_pkg::QBITS;

  logic [SW-1:0] rem;
  logic [SW-1:0] res;
  logic [SW-1:0] bitv;
  logic [QB-1:0] nlow;
  logic [QB-1:0] quot;
  logic          ovf;
  logic [SW:0]   cmp_a;
  logic [SW:0]   cmp_b;
  logic [SW:0]   diff;
  logic          ge;

  // The root stays in res while the divisions use it as divisor.
  always_comb begin
    cmp_a = '0;
    cmp_b = '0;
    unique case (ctrl.op)
      vln_pkg::U_SQRT_STEP: begin
        cmp_a = {1'b0, rem};
        cmp_b = {1'b0, res} + {1'b0, bitv};
      end
      vln_pkg::U_DIV_INIT: begin
        cmp_a = {1'b0, SW'(num_in >> QB)};
        cmp_b = {1'b0, res};
      end
      vln_pkg::U_DIV_STEP: begin
        cmp_a = {1'b0, rem[SW-2:0], nlow[QB-1]};
        cmp_b = {1'b0, res};
      end
      default: begin
        cmp_a = '0;
        cmp_b = '0;
      end
    endcase
    ge   = cmp_a >= cmp_b;
    diff = cmp_a - cmp_b;
  end

  always_ff @(posedge clk) begin
    unique case (ctrl.op)
      vln_pkg::U_SQRT_INIT: begin
        rem  <= sum_in;
        res  <= '0;
        bitv <= SW'(1) << vln_pkg::SQRT_TOP;
      end
      vln_pkg::U_SQRT_STEP: begin
        if (ge) begin
          rem <= diff[SW-1:0];
          res <= (res >> 1) + bitv;
        end else begin
          res <= res >> 1;
        end
        bitv <= bitv >> 2;
      end
      vln_pkg::U_DIV_INIT: begin
        // A high part at or above the divisor means the quotient saturates.
        rem  <= SW'(num_in >> QB);
        nlow <= num_in[QB-1:0];
        quot <= '0;
        ovf  <= ge;
      end
      vln_pkg::U_DIV_STEP: begin
        rem  <= ge ? diff[SW-1:0] : cmp_a[SW-1:0];
        quot <= {quot[QB-2:0], ge};
        nlow <= {nlow[QB-2:0], 1'b0};
      end
      default: begin
      end
    endcase
  end

  assign stat.root = res[vln_pkg::ROOT_W-1:0];
  assign stat.quot = quot;
  assign stat.ovf  = ovf;

endmodule

/* tb/tb.sv */
// Self-checking testbench for vector_length_normalize_core: directed vectors, then random ones.
// It predicts each normalized element (or takes the typed result of a directed row) and compares every result strobe.
// Depends only on the RTL (vln_pkg and the core).
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          MAX_ELEMENTS    = 32;
  localparam logic [2:0]  ADDR_TARGET_LEN = 3'd0;
  localparam logic [2:0]  ADDR_MIN_ENERGY = 3'd4;
  localparam logic [35:0] ENERGY_CEILING  = {vln_pkg::SUM_W{1'b1}};
  localparam int          SETTLE_CYCLES   = 40;
  localparam int          STALL_LIMIT     = 4000;
  localparam int          PHASES          = 6;
  localparam int          ITEMS_PER_PHASE = 22;
  localparam int          DIR_ROWS        = 20;

  typedef struct packed {
    logic signed [15:0] value;
    logic               final_flag;
  } norm_t;

  typedef struct packed {
    logic [15:0]        target;
    logic [31:0]        min_e;
    logic signed [15:0] elem;
    logic               last_flag;
    logic               known;
    logic signed [15:0] typed;
  } row_t;

  logic               clk;
  logic               rst;
  logic               start;
  logic               busy;
  logic signed [15:0] element;
  logic               last;
  logic               strobe;
  logic signed [15:0] scaled;
  logic               final_res;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [2:0]         paddr;
  logic [31:0]        pwdata;
  logic [31:0]        prdata;
  logic               pready;

  // Predictor state: the vector being loaded and the register copies.
  logic signed [15:0] vec_elem  [MAX_ELEMENTS];
  logic               vec_known [MAX_ELEMENTS];
  logic signed [15:0] vec_typed [MAX_ELEMENTS];
  logic [5:0]         fill;
  logic [35:0]        energy;
  logic [15:0]        tgt_len;
  logic [31:0]        min_e;

  norm_t norm_queue[$];
  row_t  dir_rows [DIR_ROWS];

  int errors;
  int requests_sent;
  int results_seen;
  int vectors_scaled;
  int vectors_passed;
  int stall_count;

  vector_length_normalize_core #(.MAX_ELEMENTS(MAX_ELEMENTS)) uut (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .busy     (busy),
    .element  (element),
    .last     (last),
    .strobe   (strobe),
    .scaled   (scaled),
    .final_res(final_res),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  function automatic logic [17:0] floor_sqrt(input logic [35:0] x);
    longint unsigned rem;
    longint unsigned root;
    longint unsigned probe;
    rem   = x;
    root  = 0;
    probe = 64'd1 << 34;
    while (probe > rem) probe >>= 2;
    while (probe != 0) begin
      if (rem >= root + probe) begin
        rem  = rem - (root + probe);
        root = (root >> 1) + probe;
      end else begin
        root >>= 1;
      end
      probe >>= 2;
    end
    return root[17:0];
  endfunction

  // Adds one element to the vector while there is room; a closing element queues the whole normalized vector.
  task automatic load_element(input logic signed [15:0] e, input logic last_in,
                              input logic known, input logic signed [15:0] typed);
    logic [36:0] grown;
    logic [17:0] root;
    logic        scale_it;
    longint      quo;
    norm_t       item;
    if (fill < MAX_ELEMENTS) begin
      vec_elem[fill[4:0]]  = e;
      vec_known[fill[4:0]] = known;
      vec_typed[fill[4:0]] = typed;
      fill++;
      grown  = {1'b0, energy} + 37'(longint'(e) * longint'(e));
      energy = (grown > {1'b0, ENERGY_CEILING}) ? ENERGY_CEILING : grown[35:0];
    end
    if (last_in) begin
      root     = floor_sqrt(energy);
      scale_it = !(energy < {4'b0, min_e}) && root != 0;
      if (scale_it) vectors_scaled++;
      else vectors_passed++;
      for (int i = 0; i < fill; i++) begin
        if (vec_known[i]) begin
          item.value = vec_typed[i];
        end else if (!scale_it) begin
          item.value = vec_elem[i];
        end else begin
          quo = (longint'(vec_elem[i]) * longint'(tgt_len)) / longint'(root);
          if (quo > 32767) quo = 32767;
          if (quo < -32768) quo = -32768;
          item.value = 16'(quo);
        end
        item.final_flag = (i + 1 == fill);
        norm_queue.push_back(item);
      end
      fill   = '0;
      energy = '0;
    end
  endtask

  task automatic send_item(input logic signed [15:0] e, input logic last_in,
                           input logic known, input logic signed [15:0] typed);
    @(negedge clk);
    start   <= 1'b1;
    element <= e;
    last    <= last_in;
    do @(posedge clk); while (busy);
    load_element(e, last_in, known, typed);
    requests_sent++;
  endtask

  task automatic idle_cycle();
    @(negedge clk);
    start   <= 1'b0;
    element <= 16'($urandom);
    last    <= 1'($urandom);
  endtask

  task automatic apb_write_check(input logic [2:0] addr, input logic [31:0] value,
                                 input logic [31:0] mask);
    logic [31:0] readback;
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    readback = prdata;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    if ((readback & mask) !== (value & mask)) begin
      $error("prdata at 0x%0h: expected 0x%0h, actual 0x%0h", addr, value & mask,
             readback & mask);
      errors++;
    end
  endtask

  // Registers change only once the block has drained and gone quiet.
  task automatic set_config(input logic [15:0] target, input logic [31:0] energy_floor);
    @(negedge clk);
    start <= 1'b0;
    while (norm_queue.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    while (busy) @(posedge clk);
    apb_write_check(ADDR_TARGET_LEN, {16'b0, target}, 32'h0000_FFFF);
    apb_write_check(ADDR_MIN_ENERGY, energy_floor, 32'hFFFF_FFFF);
    tgt_len = target;
    min_e   = energy_floor;
  endtask

  always @(posedge clk) begin : result_check
    norm_t want;
    if (!rst && strobe) begin
      if (norm_queue.size() == 0) begin
        $error("unexpected result: scaled %0d final_res %0b", scaled, final_res);
        errors++;
      end else begin
        want = norm_queue.pop_front();
        results_seen++;
        if (scaled !== want.value) begin
          $error("scaled: expected %0d, actual %0d", want.value, scaled);
          errors++;
        end
        if (final_res !== want.final_flag) begin
          $error("final_res: expected %0b, actual %0b", want.final_flag, final_res);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || strobe) stall_count <= 0;
    else stall_count <= stall_count + 1;
    if (stall_count >= STALL_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    int idle_pct;
    int sent_phase;
    int len;
    logic [15:0] new_target;
    logic [31:0] new_floor;
    logic signed [15:0] e;

    rst     = 1'b1;
    start   = 1'b0;
    element = '0;
    last    = 1'b0;
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = '0;
    pwdata  = '0;
    fill    = '0;
    energy  = '0;
    tgt_len = 16'd4096;
    min_e   = 32'd1;
    errors  = 0;
    requests_sent  = 0;
    results_seen   = 0;
    vectors_scaled = 0;
    vectors_passed = 0;

    // target, min_energy, element, last, known, typed result
    dir_rows = '{
      '{16'd4096,  32'd1,        16'sd0,      1'b1, 1'b1, 16'sd0},
      '{16'd4096,  32'd1,        16'sd4096,   1'b1, 1'b1, 16'sd4096},
      '{16'd4096,  32'd1,        -16'sd32768, 1'b1, 1'b1, -16'sd4096},
      '{16'd4096,  32'd1,        16'sd32767,  1'b1, 1'b1, 16'sd4096},
      '{16'd4096,  32'd1,        16'sd3,      1'b0, 1'b1, 16'sd2457},
      '{16'd4096,  32'd1,        16'sd4,      1'b1, 1'b1, 16'sd3276},
      '{16'd4096,  32'd1,        -16'sd3,     1'b0, 1'b0, 16'sd0},
      '{16'd4096,  32'd1,        16'sd100,    1'b0, 1'b0, 16'sd0},
      '{16'd4096,  32'd1,        -16'sd2000,  1'b1, 1'b0, 16'sd0},
      '{16'hFFFF,  32'd0,        16'sd1,      1'b1, 1'b1, 16'sd32767},
      '{16'hFFFF,  32'd0,        -16'sd1,     1'b1, 1'b1, -16'sd32768},
      '{16'hFFFF,  32'd0,        16'sd0,      1'b1, 1'b1, 16'sd0},
      '{16'hFFFF,  32'd0,        16'sd0,      1'b0, 1'b1, 16'sd0},
      '{16'hFFFF,  32'd0,        16'sd0,      1'b1, 1'b1, 16'sd0},
      '{16'd0,     32'd1,        16'sd12345,  1'b0, 1'b1, 16'sd0},
      '{16'd0,     32'd1,        -16'sd7,     1'b1, 1'b1, 16'sd0},
      '{16'd4096,  32'hFFFFFFFF, 16'sd32767,  1'b0, 1'b1, 16'sd32767},
      '{16'd4096,  32'hFFFFFFFF, -16'sd32768, 1'b1, 1'b1, -16'sd32768},
      '{16'd1000,  32'd200,      16'sd10,     1'b0, 1'b0, 16'sd0},
      '{16'd1000,  32'd200,      16'sd10,     1'b1, 1'b0, 16'sd0}
    };

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed vectors; the first ones run on the reset register values.
    for (int r = 0; r < DIR_ROWS; r++) begin
      if (fill == 0 && (dir_rows[r].target != tgt_len || dir_rows[r].min_e != min_e))
        set_config(dir_rows[r].target, dir_rows[r].min_e);
      send_item(dir_rows[r].elem, dir_rows[r].last_flag, dir_rows[r].known,
                dir_rows[r].typed);
    end
    // Energy just under the floor passes the vector through.
    send_item(16'sd14, 1'b1, 1'b1, 16'sd14);

    for (int phase = 0; phase < PHASES; phase++) begin
      idle_pct = (phase < 2) ? 15 : (phase < 4) ? 68 : 0;
      case ($urandom_range(0, 3))
        0:       new_target = 16'hFFFF;
        1:       new_target = 16'd4096;
        default: new_target = 16'($urandom);
      endcase
      case ($urandom_range(0, 5))
        0:       new_floor = 32'd0;
        1:       new_floor = 32'hFFFF_FFFF;
        2:       new_floor = 32'd1;
        3:       new_floor = $urandom;
        default: new_floor = $urandom_range(0, 1 << 22);
      endcase
      set_config(new_target, new_floor);
      sent_phase = 0;
      while (sent_phase < ITEMS_PER_PHASE) begin
        // Mostly short vectors; now and then a full one or one that runs past capacity.
        case ($urandom_range(0, 19))
          0:       len = MAX_ELEMENTS;
          1:       len = $urandom_range(MAX_ELEMENTS + 1, MAX_ELEMENTS + 4);
          2, 3:    len = $urandom_range(9, 20);
          default: len = $urandom_range(1, 8);
        endcase
        for (int k = 0; k < len; k++) begin
          while ($urandom_range(0, 99) < idle_pct) idle_cycle();
          case ($urandom_range(0, 9))
            0, 1, 2: e = 16'($urandom);
            3, 4:    e = 16'($signed($urandom_range(0, 511)) - 256);
            5:       e = $urandom_range(0, 1) ? 16'sd32767 : -16'sd32768;
            6:       e = 16'sd0;
            default: e = 16'($signed($urandom_range(0, 16383)) - 8192);
          endcase
          send_item(e, k == len - 1, 1'b0, 16'sd0);
          sent_phase++;
        end
      end
    end

    @(negedge clk);
    start <= 1'b0;
    while (norm_queue.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Sent %0d element requests: %0d vectors scaled, %0d passed through unscaled.",
             requests_sent, vectors_scaled, vectors_passed);
    $display("Checked %0d results across %0d register settings.", results_seen,
             PHASES + 4);
    if (errors == 0 && norm_queue.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
